/* hw/rtl/clsr_pkg.sv */
// ----------------------------------------------------------------------------
// Combined LCG shuffle RNG package
// Widths, generator coefficients, operation codes, controller states and the
// command and status bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package clsr_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned QuoW       = IdxW + 1;
  localparam int unsigned WarmSteps  = TableDepth + 8;
  localparam int unsigned WarmW      = $clog2(WarmSteps);

  localparam int unsigned GenW   = 31;
  localparam int unsigned WordW  = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CntW   = 6;
  localparam int unsigned KW     = 16;
  localparam int unsigned RmdW   = 14;
  localparam int unsigned RecipW = 17;
  localparam int unsigned RecipSh = 32;

  localparam logic [CntW-1:0] MaxBits    = CntW'(WordW);
  localparam logic [GenW-1:0] ModOneLess = 31'd2147483562;
  localparam logic [GenW-1:0] SlotDiv    = GenW'(1 + 2147483562 / TableDepth);

  localparam int unsigned SlotSh     = GenW;
  localparam int unsigned RecipSlotW = QuoW + 1;
  localparam logic [RecipSlotW-1:0] RecipSlot =
    RecipSlotW'((64'd1 << SlotSh) / 64'(SlotDiv));

  typedef struct packed {
    logic [KW-1:0]     mul;
    logic [KW-1:0]     quo;
    logic [RmdW-1:0]   rmd;
    logic [GenW-1:0]   modulus;
    logic [RecipW-1:0] recip;
  } coef_t;

  localparam coef_t CoefOne = '{
    mul:     KW'(40014),
    quo:     KW'(53668),
    rmd:     RmdW'(12211),
    modulus: GenW'(2147483563),
    recip:   RecipW'((64'd1 << RecipSh) / 64'd53668)
  };

  localparam coef_t CoefTwo = '{
    mul:     KW'(40692),
    quo:     KW'(52774),
    rmd:     RmdW'(3791),
    modulus: GenW'(2147483399),
    recip:   RecipW'((64'd1 << RecipSh) / 64'd52774)
  };

  typedef enum logic [OpW-1:0] {
    OP_RESEED = 2'd0,
    OP_RAW    = 2'd1,
    OP_BITS   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WARM_GO,
    ST_WARM_WAIT,
    ST_RAW_GO,
    ST_RAW_WAIT,
    ST_EXTRACT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic load_seed;
    logic start_one;
    logic start_two;
    logic warm_commit;
    logic raw_commit;
    logic buf_load;
    logic extract;
    logic word_clr;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic need_refill;
    logic gen_done;
    logic warm_last;
  } stat_t;

endpackage

/* hw/rtl/clsr_if.sv */
// ----------------------------------------------------------------------------
// Combined LCG shuffle RNG channel interfaces
// Request, response and seed write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface clsr_req_if;
  logic                       valid;
  logic                       ready;
  logic [clsr_pkg::OpW-1:0]   operation;
  logic [clsr_pkg::CntW-1:0]  bit_count;

  modport source (output valid, output operation, output bit_count, input ready);
  modport sink   (input valid, input operation, input bit_count, output ready);
endinterface

interface clsr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [clsr_pkg::WordW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface clsr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [clsr_pkg::WordW-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

/* hw/rtl/clsr_schrage.sv */
// ----------------------------------------------------------------------------
// Schrage step unit
// Five-stage pipeline computing one multiplicative congruential step with a
// reciprocal-based quotient estimate and a single correction.
// ----------------------------------------------------------------------------
module clsr_schrage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [clsr_pkg::GenW-1:0]   seed_i,
  input  clsr_pkg::coef_t             coef_i,
  output logic                        done_o,
  output logic [clsr_pkg::GenW-1:0]   value_o
);

  localparam int unsigned ProdW = clsr_pkg::GenW + clsr_pkg::RecipW;

  logic [4:0]                   vld_q;
  logic [clsr_pkg::GenW-1:0]    s1_q, s2_q;
  logic [clsr_pkg::KW-1:0]      k1_q, k2_q, k3_q;
  logic [clsr_pkg::GenW-1:0]    kq2_q;
  logic [clsr_pkg::KW-1:0]      r3_q;
  logic [31:0]                  x4_q;
  logic [29:0]                  y4_q;
  logic [clsr_pkg::GenW-1:0]    v5_q;

  logic [ProdW-1:0]             prod1;
  logic [clsr_pkg::KW-1:0]      k1_d;
  logic [31:0]                  kq2_full;
  logic [31:0]                  diff3;
  logic [31:0]                  quo32;
  logic [clsr_pkg::KW-1:0]      k3_d, r3_d;
  logic [31:0]                  x4_d;
  logic [31:0]                  y4_full;
  logic [32:0]                  v5_raw;
  logic [32:0]                  v5_fix;

  assign prod1    = ProdW'(seed_i) * ProdW'(coef_i.recip);
  assign k1_d     = prod1[clsr_pkg::RecipSh +: clsr_pkg::KW];
  assign kq2_full = {16'b0, k1_q} * {16'b0, coef_i.quo};
  assign diff3    = {1'b0, s2_q} - {1'b0, kq2_q};
  assign quo32    = {16'b0, coef_i.quo};

  always_comb begin
    if (diff3 >= quo32) begin
      k3_d = k2_q + clsr_pkg::KW'(1);
      r3_d = clsr_pkg::KW'(diff3 - quo32);
    end else begin
      k3_d = k2_q;
      r3_d = clsr_pkg::KW'(diff3);
    end
  end

  assign x4_d    = {16'b0, r3_q} * {16'b0, coef_i.mul};
  assign y4_full = {16'b0, k3_q} * {18'b0, coef_i.rmd};
  assign v5_raw  = {1'b0, x4_q} - {3'b0, y4_q};
  assign v5_fix  = v5_raw[32] ? (v5_raw + {2'b0, coef_i.modulus}) : v5_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= seed_i;
    k1_q  <= k1_d;
    s2_q  <= s1_q;
    k2_q  <= k1_q;
    kq2_q <= kq2_full[clsr_pkg::GenW-1:0];
    k3_q  <= k3_d;
    r3_q  <= r3_d;
    x4_q  <= x4_d;
    y4_q  <= y4_full[29:0];
    v5_q  <= v5_fix[clsr_pkg::GenW-1:0];
  end

  assign done_o  = vld_q[4];
  assign value_o = v5_q;

endmodule

/* hw/rtl/clsr_datapath.sv */
// ----------------------------------------------------------------------------
// Combined LCG shuffle RNG datapath
// Generator state, shuffle table, slot index pipeline, bit buffer and result
// register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module clsr_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  clsr_pkg::cmd_t              cmd_i,
  output clsr_pkg::stat_t             stat_o,
  input  logic [clsr_pkg::OpW-1:0]    op_i,
  input  logic [clsr_pkg::CntW-1:0]   bit_count_i,
  input  logic                        cfg_we_i,
  input  logic [clsr_pkg::WordW-1:0]  cfg_seed_i,
  output logic [clsr_pkg::WordW-1:0]  value_o
);

  localparam int unsigned EstW = clsr_pkg::GenW + clsr_pkg::RecipSlotW;
  localparam int unsigned BndW = clsr_pkg::GenW + clsr_pkg::QuoW + 1;

  logic [clsr_pkg::WordW-1:0]  seed_q;
  clsr_pkg::op_e               op_q;
  logic [clsr_pkg::CntW-1:0]   n_q;
  logic [clsr_pkg::GenW-1:0]   g1_q, g2_q, last_q;
  logic [clsr_pkg::WordW-1:0]  buf_q;
  logic [clsr_pkg::CntW-1:0]   rem_q;
  logic [clsr_pkg::WarmW-1:0]  cnt_q;
  logic [clsr_pkg::WordW-1:0]  word_q, res_q;

  logic [clsr_pkg::GenW-1:0]   mem_q [clsr_pkg::TableDepth];
  logic [clsr_pkg::TableDepth-1:0] valid_q;
  logic [clsr_pkg::QuoW-1:0]   est_q;
  logic [clsr_pkg::GenW-1:0]   lastc_q;
  logic [clsr_pkg::IdxW-1:0]   idx_q;
  logic [clsr_pkg::GenW-1:0]   rd_q;

  logic                        u1_done;
  logic [clsr_pkg::GenW-1:0]   u1_val, u2_val;

  logic [clsr_pkg::WordW-1:0]  seed_mag;
  logic [clsr_pkg::GenW-1:0]   seed_start;
  logic [EstW-1:0]             est_prod;
  logic [BndW-1:0]             bound;
  logic [clsr_pkg::QuoW-1:0]   quo_d;
  logic [clsr_pkg::IdxW-1:0]   idx_d;
  logic [clsr_pkg::WordW-1:0]  lo_diff;
  logic [clsr_pkg::WordW-1:0]  lo_wrap;
  logic [clsr_pkg::GenW-1:0]   last_new;
  logic [clsr_pkg::WordW-1:0]  word_mix;
  logic [clsr_pkg::WordW:0]    mask_w;
  logic [clsr_pkg::WordW-1:0]  bits_out;
  logic [clsr_pkg::CntW-1:0]   n_d;
  logic                        warm_wr;
  logic                        mem_we;
  logic [clsr_pkg::IdxW-1:0]   mem_addr;

  clsr_schrage u_gen_one (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_one),
    .seed_i  (g1_q),
    .coef_i  (clsr_pkg::CoefOne),
    .done_o  (u1_done),
    .value_o (u1_val)
  );

  clsr_schrage u_gen_two (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_two),
    .seed_i  (g2_q),
    .coef_i  (clsr_pkg::CoefTwo),
    .done_o  (),
    .value_o (u2_val)
  );

  assign seed_mag = seed_q[clsr_pkg::WordW-1] ? (~seed_q + 32'd1) : seed_q;

  always_comb begin
    if (seed_mag[clsr_pkg::WordW-1]) begin
      seed_start = '1;
    end else if (seed_mag[clsr_pkg::GenW-1:0] == '0) begin
      seed_start = clsr_pkg::GenW'(1);
    end else begin
      seed_start = seed_mag[clsr_pkg::GenW-1:0];
    end
  end

  assign n_d = (bit_count_i > clsr_pkg::MaxBits) ? clsr_pkg::MaxBits : bit_count_i;

  // slot index: reciprocal estimate, then one correction and clamp
  assign est_prod = EstW'(last_q) * EstW'(clsr_pkg::RecipSlot);
  assign bound    = (BndW'(est_q) + BndW'(1)) * BndW'(clsr_pkg::SlotDiv);
  assign quo_d    = (BndW'(lastc_q) >= bound) ? (est_q + clsr_pkg::QuoW'(1)) : est_q;
  assign idx_d    = (quo_d >= clsr_pkg::QuoW'(clsr_pkg::TableDepth)) ?
                    clsr_pkg::IdxW'(clsr_pkg::TableDepth - 1) : quo_d[clsr_pkg::IdxW-1:0];

  assign lo_diff  = {1'b0, rd_q} - {1'b0, u2_val};
  assign lo_wrap  = lo_diff + {1'b0, clsr_pkg::ModOneLess};
  assign last_new = (lo_diff[clsr_pkg::WordW-1] || (lo_diff == '0)) ?
                    lo_wrap[clsr_pkg::GenW-1:0] : lo_diff[clsr_pkg::GenW-1:0];
  assign word_mix = {1'b0, last_new} ^ {last_new[15:0], 16'b0};

  assign mask_w   = ((clsr_pkg::WordW + 1)'(1) << n_q) - (clsr_pkg::WordW + 1)'(1);
  assign bits_out = buf_q & mask_w[clsr_pkg::WordW-1:0];

  assign warm_wr  = cmd_i.warm_commit && (cnt_q < clsr_pkg::WarmW'(clsr_pkg::TableDepth));
  assign mem_we   = warm_wr || cmd_i.raw_commit;
  assign mem_addr = cmd_i.warm_commit ? cnt_q[clsr_pkg::IdxW-1:0] : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= clsr_pkg::WordW'(1);
      op_q    <= clsr_pkg::OP_NOP;
      n_q     <= '0;
      g1_q    <= '0;
      g2_q    <= '0;
      last_q  <= '0;
      buf_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_seed_i;
      end
      if (cmd_i.capture) begin
        op_q <= clsr_pkg::op_e'(op_i);
        n_q  <= n_d;
      end
      if (cmd_i.load_seed) begin
        g1_q  <= seed_start;
        g2_q  <= seed_start;
        cnt_q <= clsr_pkg::WarmW'(clsr_pkg::WarmSteps - 1);
      end
      if (cmd_i.warm_commit) begin
        g1_q   <= u1_val;
        last_q <= u1_val;
        cnt_q  <= cnt_q - clsr_pkg::WarmW'(1);
      end
      if (cmd_i.raw_commit) begin
        g1_q   <= u1_val;
        g2_q   <= u2_val;
        last_q <= last_new;
      end
      if (mem_we) begin
        valid_q[mem_addr] <= 1'b1;
      end
      if (cmd_i.buf_load) begin
        buf_q <= word_mix;
        rem_q <= clsr_pkg::MaxBits;
      end
      if (cmd_i.extract) begin
        buf_q <= buf_q >> n_q;
        rem_q <= rem_q - n_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= u1_val;
    end
    rd_q    <= valid_q[idx_q] ? mem_q[idx_q] : '0;
    est_q   <= est_prod[clsr_pkg::SlotSh +: clsr_pkg::QuoW];
    lastc_q <= last_q;
    idx_q   <= idx_d;
    if (cmd_i.raw_commit) begin
      word_q <= word_mix;
    end else if (cmd_i.extract) begin
      word_q <= bits_out;
    end else if (cmd_i.word_clr) begin
      word_q <= '0;
    end
    if (cmd_i.res_load) begin
      res_q <= word_q;
    end
  end

  assign stat_o.op          = op_q;
  assign stat_o.need_refill = (rem_q < n_q);
  assign stat_o.gen_done    = u1_done;
  assign stat_o.warm_last   = (cnt_q == '0);
  assign value_o            = res_q;

endmodule

/* hw/rtl/clsr_ctrl.sv */
// ----------------------------------------------------------------------------
// Combined LCG shuffle RNG controller
// Sequences reseed warm-up, raw draws, buffered bit draws and no-ops, and owns the
// request ready and response valid handshakes.
// ----------------------------------------------------------------------------
module clsr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  clsr_pkg::stat_t  stat_i,
  output clsr_pkg::cmd_t   cmd_o
);

  clsr_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clsr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      clsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = clsr_pkg::ST_DECODE;
        end
      end
      clsr_pkg::ST_DECODE: begin
        unique case (stat_i.op)
          clsr_pkg::OP_RESEED: begin
            cmd_o.load_seed = 1'b1;
            state_d         = clsr_pkg::ST_WARM_GO;
          end
          clsr_pkg::OP_RAW: begin
            state_d = clsr_pkg::ST_RAW_GO;
          end
          clsr_pkg::OP_BITS: begin
            state_d = stat_i.need_refill ? clsr_pkg::ST_RAW_GO : clsr_pkg::ST_EXTRACT;
          end
          clsr_pkg::OP_NOP: begin
            cmd_o.word_clr = 1'b1;
            state_d        = clsr_pkg::ST_RESULT;
          end
          default: begin
            state_d = clsr_pkg::ST_IDLE;
          end
        endcase
      end
      clsr_pkg::ST_WARM_GO: begin
        cmd_o.start_one = 1'b1;
        state_d         = clsr_pkg::ST_WARM_WAIT;
      end
      clsr_pkg::ST_WARM_WAIT: begin
        if (stat_i.gen_done) begin
          cmd_o.warm_commit = 1'b1;
          if (stat_i.warm_last) begin
            cmd_o.word_clr = 1'b1;
            state_d        = clsr_pkg::ST_RESULT;
          end else begin
            state_d = clsr_pkg::ST_WARM_GO;
          end
        end
      end
      clsr_pkg::ST_RAW_GO: begin
        cmd_o.start_one = 1'b1;
        cmd_o.start_two = 1'b1;
        state_d         = clsr_pkg::ST_RAW_WAIT;
      end
      clsr_pkg::ST_RAW_WAIT: begin
        if (stat_i.gen_done) begin
          cmd_o.raw_commit = 1'b1;
          if (stat_i.op == clsr_pkg::OP_BITS) begin
            cmd_o.buf_load = 1'b1;
            state_d        = clsr_pkg::ST_EXTRACT;
          end else begin
            state_d = clsr_pkg::ST_RESULT;
          end
        end
      end
      clsr_pkg::ST_EXTRACT: begin
        cmd_o.extract = 1'b1;
        state_d       = clsr_pkg::ST_RESULT;
      end
      clsr_pkg::ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = clsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = clsr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/combined_lcg_shuffle_rng_unit.sv */
// ----------------------------------------------------------------------------
// Combined LCG shuffle RNG unit
// Two combined congruential generators with a shuffle table and a bit buffer.
//
//   channel  dir   signals                        meaning
//   req_i    in    valid ready operation bit_count  one operation per transaction
//   rsp_o    out   valid ready value                one result per operation
//   cfg_i    in    valid ready seed                 seed register write
//
// Raw word: each draw runs through the five-stage step units.
// Bit draw: served from the buffer, or after a raw draw when it must be refilled.
// Reseed: TableDepth + 8 warm-up steps, one generator step at a time.
// Reset clears the generators, table valid bits and bit buffer; seed resets to 1.
// A new request is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  clsr_req_if.sink   req_i,
  clsr_rsp_if.source rsp_o,
  clsr_cfg_if.sink   cfg_i
);

  clsr_pkg::cmd_t  cmd;
  clsr_pkg::stat_t stat;

  assign cfg_i.ready = 1'b1;

  clsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  clsr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (req_i.operation),
    .bit_count_i (req_i.bit_count),
    .cfg_we_i    (cfg_i.valid),
    .cfg_seed_i  (cfg_i.seed),
    .value_o     (rsp_o.value)
  );

endmodule

/* hw/rtl/clsr_checker.sv */
// ----------------------------------------------------------------------------
// Combined LCG shuffle RNG port checker
// Port-level properties of the response handshake and request sequencing.
// ----------------------------------------------------------------------------
module clsr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [clsr_pkg::OpW-1:0]    in_operation_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [clsr_pkg::WordW-1:0]  out_value_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i))
    else $error("response value changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while an operation is in flight");

  a_reseed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_operation_i == clsr_pkg::OP_RESEED)
      |-> ##40 !in_ready_i)
    else $error("reseed finished before its warm-up");

endmodule

bind combined_lcg_shuffle_rng_unit clsr_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .in_operation_i (req_i.operation),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .out_value_i    (rsp_o.value)
);

/* bench/combined_lcg_shuffle_rng_unit_test.sv */
// ----------------------------------------------------------------------------
// Combined LCG shuffle RNG unit testbench
// Sends reseeds, raw word draws, bit draws and no-ops under several seeds. A
// built-in generator model predicts each result value, and the monitor checks
// the values in order. Both channels idle at random, except in one steady
// phase.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import clsr_pkg::*;

  localparam longint SlotDivisor = 1 + longint'(ModOneLess) / TableDepth;
  localparam int unsigned PhaseItems = 300;

  typedef struct packed {
    op_e             op;
    logic [CntW-1:0] count;
  } rng_request_t;

  logic clk_i;
  logic rst_ni;
  logic steady = 1'b0;

  clsr_req_if req_ch ();
  clsr_rsp_if rsp_ch ();
  clsr_cfg_if cfg_ch ();

  combined_lcg_shuffle_rng_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  rng_request_t      pending_reqs[$];
  logic [WordW-1:0]  expected_values[$];

  longint            gen_a = 0;
  longint            gen_b = 0;
  longint            prev_out = 0;
  longint            shuffle [TableDepth] = '{default: 0};
  logic [WordW-1:0]  bit_buf = '0;
  int unsigned       bit_left = 0;
  logic [WordW-1:0]  seed_reg = 32'd1;

  int unsigned error_count = 0;
  int unsigned items_accepted = 0;
  int unsigned values_checked = 0;
  int unsigned reseed_count = 0;
  int unsigned seeds_written = 0;

  function automatic longint next_congruential(longint s, coef_t c);
    longint k;
    longint v;
    k = s / longint'(c.quo);
    v = longint'(c.mul) * (s - k * longint'(c.quo)) - k * longint'(c.rmd);
    if (v < 0) v += longint'(c.modulus);
    return v;
  endfunction

  function automatic logic [WordW-1:0] next_raw_word();
    longint           slot;
    logic [WordW-1:0] p;
    gen_a = next_congruential(gen_a, CoefOne);
    gen_b = next_congruential(gen_b, CoefTwo);
    slot = prev_out / SlotDivisor;
    if (slot < 0) slot = 0;
    if (slot >= TableDepth) slot = TableDepth - 1;
    prev_out = shuffle[slot] - gen_b;
    shuffle[slot] = gen_a;
    if (prev_out < 1) prev_out += longint'(ModOneLess);
    p = prev_out[WordW-1:0];
    return p ^ (p << 16);
  endfunction

  function automatic void reseed_generators();
    longint s;
    s = longint'(signed'(seed_reg));
    if (s < 0) s = -s;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s == 0) s = 1;
    gen_a = s;
    gen_b = s;
    for (int i = WarmSteps - 1; i >= 0; i--) begin
      gen_a = next_congruential(gen_a, CoefOne);
      if (i < TableDepth) shuffle[i] = gen_a;
    end
    prev_out = shuffle[0];
  endfunction

  function automatic logic [WordW-1:0] draw_bits(logic [CntW-1:0] requested);
    int unsigned      n;
    logic [WordW-1:0] v;
    n = (requested > MaxBits) ? WordW : int'(requested);
    if (bit_left < n) begin
      bit_left = WordW;
      bit_buf = next_raw_word();
    end
    if (n == WordW) begin
      v = bit_buf;
      bit_buf = '0;
    end else begin
      v = bit_buf & ((32'd1 << n) - 32'd1);
      bit_buf = bit_buf >> n;
    end
    bit_left -= n;
    return v;
  endfunction

  function automatic logic [WordW-1:0] predict_value(op_e op, logic [CntW-1:0] count);
    logic [WordW-1:0] v;
    v = '0;
    case (op)
      OP_RESEED: begin
        reseed_generators();
        reseed_count++;
      end
      OP_RAW:  v = next_raw_word();
      OP_BITS: v = draw_bits(count);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic rng_request_t random_request();
    rng_request_t r;
    int unsigned  pick;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) r.count = CntW'($urandom_range(63, 33));
    else r.count = CntW'($urandom_range(32));
    if (pick < 2) r.op = OP_RESEED;
    else if (pick < 32) r.op = OP_RAW;
    else if (pick < 94) r.op = OP_BITS;
    else r.op = OP_NOP;
    return r;
  endfunction

  task automatic queue_request(input op_e op, input int unsigned count);
    rng_request_t r;
    r.op = op;
    r.count = CntW'(count);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_values.size() != 0);
  endtask

  task automatic write_seed(input logic [WordW-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("combined_lcg_shuffle_rng_unit_test failed");
    $finish;
  end

  // Driver: hold each transaction until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
          rng_request_t r;
          r = pending_reqs.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.operation <= r.op;
          req_ch.bit_count <= r.count;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on request transactions, check on response transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 6);
      if (cfg_ch.valid && cfg_ch.ready) begin
        seed_reg = cfg_ch.seed;
        seeds_written++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_values.size() == 0) begin
          $error("value: unexpected result 0x%08h", rsp_ch.value);
          error_count++;
        end else begin
          logic [WordW-1:0] want;
          want = expected_values.pop_front();
          values_checked++;
          if (rsp_ch.value !== want) begin
            $error("value: expected 0x%08h, got 0x%08h", want, rsp_ch.value);
            error_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_values.push_back(predict_value(op_e'(req_ch.operation), req_ch.bit_count));
        items_accepted++;
      end
    end
  end

  initial begin
    logic [WordW-1:0] phase_seed;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_NOP;
    req_ch.bit_count = '0;
    rsp_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.seed      = '0;
    rst_ni           = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Draw on the cleared state, then exercise the bit buffer edges.
    queue_request(OP_RAW, 0);
    queue_request(OP_BITS, 3);
    queue_request(OP_BITS, 0);
    queue_request(OP_NOP, 63);
    queue_request(OP_RESEED, 0);
    queue_request(OP_RAW, 0);
    queue_request(OP_BITS, 1);
    queue_request(OP_BITS, 32);
    queue_request(OP_BITS, 31);
    queue_request(OP_BITS, 2);
    queue_request(OP_BITS, 33);
    queue_request(OP_BITS, 63);
    queue_request(OP_RESEED, 0);
    queue_request(OP_BITS, 5);
    queue_request(OP_NOP, 0);
    wait_idle();

    write_seed(32'h0000_0000);
    queue_request(OP_RESEED, 0);
    queue_request(OP_RAW, 0);
    queue_request(OP_BITS, 16);
    wait_idle();
    write_seed(32'h8000_0000);
    queue_request(OP_RESEED, 0);
    queue_request(OP_RAW, 0);
    wait_idle();
    write_seed(32'h7fff_ffff);
    queue_request(OP_RESEED, 0);
    queue_request(OP_RAW, 0);
    wait_idle();
    write_seed(32'hffff_ffff);
    queue_request(OP_RESEED, 0);
    queue_request(OP_RAW, 0);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       phase_seed = 32'h8000_0001;
        3:       phase_seed = 32'h7fff_ffff;
        5:       phase_seed = 32'hffff_ffff;
        default: phase_seed = $urandom;
      endcase
      write_seed(phase_seed);
      steady = (phase == 2);
      if (phase != 5) queue_request(OP_RESEED, 0);
      for (int n = 0; n < PhaseItems; n++) pending_reqs.push_back(random_request());
      wait_idle();
      steady = 1'b0;
    end

    repeat (300) @(posedge clk_i);
    $display("Checked %0d results from %0d requests, %0d reseeds, %0d seed writes",
             values_checked, items_accepted, reseed_count, seeds_written);
    if (error_count == 0) begin
      $display("combined_lcg_shuffle_rng_unit_test passed");
    end else begin
      $display("combined_lcg_shuffle_rng_unit_test failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/clsr_pkg.sv
hw/rtl/clsr_if.sv
hw/rtl/clsr_schrage.sv
hw/rtl/clsr_datapath.sv
hw/rtl/clsr_ctrl.sv
hw/rtl/combined_lcg_shuffle_rng_unit.sv
hw/rtl/clsr_checker.sv
bench/combined_lcg_shuffle_rng_unit_test.sv
